FILE: design/eca_pkg.sv
`default_nettype none
package eca_pkg;

   localparam int MAX_ENTRIES = 16;
   localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

   localparam int CORE_W        = 16;
   localparam int TAG_W         = 16;
   localparam int COUNT_W       = 16;
   localparam int CREDIT_W      = 5;
   localparam int CORE_COUNT_W  = 17;
   localparam int STATUS_W      = 3;

   localparam logic [CORE_COUNT_W-1:0] CORE_LIMIT = 17'h10000;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_NOT_READY = 3'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE     = 3'd2;
   localparam logic [STATUS_W-1:0] ST_ENDPOINT  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;
   localparam logic [STATUS_W-1:0] ST_ZERO      = 3'd5;

   // register map
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 17;
   localparam logic [CSR_IDX_W-1:0] CSR_CAPACITY    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CORE_COUNT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OWN_CORE    = 2'd2;

   localparam logic [CREDIT_W-1:0]     CAPACITY_RESET   = 5'd16;
   localparam logic [CORE_COUNT_W-1:0] CORE_COUNT_RESET = 17'h10000;
   localparam logic [CORE_W-1:0]       OWN_CORE_RESET   = 16'd0;

   typedef struct packed {
      logic [CORE_W-1:0]   source;
      logic [CORE_W-1:0]   destination;
      logic [TAG_W-1:0]    tag;
      logic [CREDIT_W-1:0] credit;
   } entry_type;

   typedef struct packed {
      logic                rd_en;
      logic [IDX_W-1:0]    rd_addr;
      logic                wr_en;
      logic [IDX_W-1:0]    wr_addr;
      entry_type           wr_data;
      logic                set_valid;
      logic                clr_valid;
   } tbl_cmd_type;

   typedef struct packed {
      logic [CREDIT_W-1:0]     capacity;
      logic [CORE_COUNT_W-1:0] core_count;
      logic [CORE_W-1:0]       own_core;
   } cfg_type;

endpackage
`default_nettype wire

FILE: design/eca_table.sv
`default_nettype none
module eca_table (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire eca_pkg::tbl_cmd_type              cmd,
   output eca_pkg::entry_type                     rd_data,
   output logic [eca_pkg::MAX_ENTRIES-1:0]        valid
);

   eca_pkg::entry_type mem_ff [eca_pkg::MAX_ENTRIES];
   eca_pkg::entry_type rd_data_ff;
   logic [eca_pkg::MAX_ENTRIES-1:0] valid_ff;
   logic [eca_pkg::MAX_ENTRIES-1:0] valid_in;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem_ff[cmd.wr_addr] <= cmd.wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem_ff[cmd.rd_addr];
      end
   end

   // occupancy flags, one per entry
   always_comb begin
      valid_in = valid_ff;
      if (cmd.set_valid) begin
         valid_in[cmd.wr_addr] = 1'b1;
      end
      if (cmd.clr_valid) begin
         valid_in[cmd.wr_addr] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rd_data = rd_data_ff;
   assign valid   = valid_ff;

endmodule
`default_nettype wire

FILE: design/eca_ctrl.sv
`default_nettype none
module eca_ctrl (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire eca_pkg::cfg_type                   cfg,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic                               req_func,
   input  wire logic [eca_pkg::CORE_W-1:0]         req_source,
   input  wire logic [eca_pkg::CORE_W-1:0]         req_destination,
   input  wire logic [eca_pkg::TAG_W-1:0]          req_tag,
   input  wire logic [eca_pkg::COUNT_W-1:0]        req_count,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic [eca_pkg::STATUS_W-1:0]            rsp_status,
   output logic [eca_pkg::CREDIT_W-1:0]            rsp_key_credit,
   output logic [eca_pkg::CREDIT_W-1:0]            rsp_total_held,
   output eca_pkg::tbl_cmd_type                    tbl_cmd,
   input  wire eca_pkg::entry_type                 tbl_rd_data,
   input  wire logic [eca_pkg::MAX_ENTRIES-1:0]    tbl_valid
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SCAN   = 2'd1;
   localparam logic [1:0] S_DECIDE = 2'd2;

   localparam int IW = eca_pkg::IDX_W;
   localparam int CW = eca_pkg::CREDIT_W;

   logic [1:0] state_ff, state_in;
   logic [eca_pkg::CNT_W-1:0] scan_ff, scan_in;
   logic pend_ff, pend_in;
   logic [IW-1:0] pend_idx_ff, pend_idx_in;
   logic found_ff, found_in;
   logic [IW-1:0] found_idx_ff, found_idx_in;
   logic [CW-1:0] found_credit_ff, found_credit_in;
   logic free_ff, free_in;
   logic [IW-1:0] free_idx_ff, free_idx_in;
   logic [CW-1:0] total_ff, total_in;

   logic func_ff, func_in;
   logic [eca_pkg::CORE_W-1:0] src_ff, src_in, dst_ff, dst_in;
   logic [eca_pkg::TAG_W-1:0] tag_ff, tag_in;
   logic [eca_pkg::COUNT_W-1:0] count_ff, count_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic [eca_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [CW-1:0] rsp_credit_ff, rsp_credit_in;
   logic [CW-1:0] rsp_total_ff, rsp_total_in;

   logic accept, issue, last, key_hit, do_decide, range_bad;
   logic [CW-1:0] credit_new;
   logic [eca_pkg::STATUS_W-1:0] status_d;
   logic [CW-1:0] key_credit_d;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign issue     = (state_ff == S_SCAN) && (scan_ff != eca_pkg::CNT_W'(eca_pkg::MAX_ENTRIES));
   assign last      = pend_ff && (pend_idx_ff == IW'(eca_pkg::MAX_ENTRIES - 1));
   assign key_hit   = tbl_valid[pend_idx_ff] && (tbl_rd_data.source == src_ff)
                      && (tbl_rd_data.destination == dst_ff) && (tbl_rd_data.tag == tag_ff);
   assign do_decide = (state_ff == S_DECIDE) && (!rsp_valid_ff || rsp_ready);
   assign range_bad = (cfg.core_count == '0) || (cfg.core_count > eca_pkg::CORE_LIMIT)
                      || ({1'b0, src_ff} >= cfg.core_count)
                      || ({1'b0, dst_ff} >= cfg.core_count);

   // scan sequencing and match tracking
   always_comb begin
      state_in        = state_ff;
      scan_in         = scan_ff;
      pend_in         = 1'b0;
      pend_idx_in     = pend_idx_ff;
      found_in        = found_ff;
      found_idx_in    = found_idx_ff;
      found_credit_in = found_credit_ff;
      free_in         = free_ff;
      free_idx_in     = free_idx_ff;
      func_in         = func_ff;
      src_in          = src_ff;
      dst_in          = dst_ff;
      tag_in          = tag_ff;
      count_in        = count_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_SCAN;
               scan_in  = '0;
               found_in = 1'b0;
               free_in  = 1'b0;
               func_in  = req_func;
               src_in   = req_source;
               dst_in   = req_destination;
               tag_in   = req_tag;
               count_in = req_count;
            end
         end
         S_SCAN: begin
            if (issue) begin
               scan_in     = scan_ff + 1'b1;
               pend_in     = 1'b1;
               pend_idx_in = scan_ff[IW-1:0];
            end
            if (pend_ff) begin
               if (key_hit && !found_ff) begin
                  found_in        = 1'b1;
                  found_idx_in    = pend_idx_ff;
                  found_credit_in = tbl_rd_data.credit;
               end
               if (!tbl_valid[pend_idx_ff] && !free_ff) begin
                  free_in     = 1'b1;
                  free_idx_in = pend_idx_ff;
               end
            end
            if (last) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (do_decide) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // outcome and write-back
   always_comb begin
      status_d             = eca_pkg::ST_OK;
      key_credit_d         = found_ff ? found_credit_ff : '0;
      total_in             = total_ff;
      credit_new           = found_credit_ff - count_ff[CW-1:0];
      tbl_cmd              = '0;
      tbl_cmd.rd_en        = issue;
      tbl_cmd.rd_addr      = scan_ff[IW-1:0];
      tbl_cmd.wr_data.source      = src_ff;
      tbl_cmd.wr_data.destination = dst_ff;
      tbl_cmd.wr_data.tag         = tag_ff;
      tbl_cmd.wr_data.credit      = found_credit_ff;
      if (!func_ff) begin
         if (range_bad) begin
            status_d = eca_pkg::ST_RANGE;
         end else if (dst_ff != cfg.own_core) begin
            status_d = eca_pkg::ST_ENDPOINT;
         end else if (total_ff >= cfg.capacity) begin
            status_d = eca_pkg::ST_FULL;
         end else if (found_ff) begin
            tbl_cmd.wr_en          = do_decide;
            tbl_cmd.wr_addr        = found_idx_ff;
            tbl_cmd.wr_data.credit = found_credit_ff + 1'b1;
            key_credit_d           = found_credit_ff + 1'b1;
            total_in               = do_decide ? total_ff + 1'b1 : total_ff;
         end else if (free_ff) begin
            tbl_cmd.wr_en          = do_decide;
            tbl_cmd.set_valid      = do_decide;
            tbl_cmd.wr_addr        = free_idx_ff;
            tbl_cmd.wr_data.credit = CW'(1);
            key_credit_d           = CW'(1);
            total_in               = do_decide ? total_ff + 1'b1 : total_ff;
         end else begin
            status_d = eca_pkg::ST_FULL;
         end
      end else begin
         if (count_ff == '0) begin
            status_d = eca_pkg::ST_ZERO;
         end else if (!found_ff
                      || ({{(eca_pkg::COUNT_W-CW){1'b0}}, found_credit_ff} < count_ff)) begin
            status_d = eca_pkg::ST_NOT_READY;
         end else begin
            tbl_cmd.wr_en          = do_decide;
            tbl_cmd.wr_addr        = found_idx_ff;
            tbl_cmd.wr_data.credit = credit_new;
            tbl_cmd.clr_valid      = do_decide && (credit_new == '0);
            key_credit_d           = credit_new;
            total_in               = do_decide ? total_ff - count_ff[CW-1:0] : total_ff;
         end
      end
   end

   // result register, holds until taken
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_credit_in = rsp_credit_ff;
      rsp_total_in  = rsp_total_ff;
      if (do_decide) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = status_d;
         rsp_credit_in = key_credit_d;
         rsp_total_in  = total_in;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pend_ff      <= 1'b0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff         <= scan_in;
      pend_idx_ff     <= pend_idx_in;
      found_ff        <= found_in;
      found_idx_ff    <= found_idx_in;
      found_credit_ff <= found_credit_in;
      free_ff         <= free_in;
      free_idx_ff     <= free_idx_in;
      func_ff         <= func_in;
      src_ff          <= src_in;
      dst_ff          <= dst_in;
      tag_ff          <= tag_in;
      count_ff        <= count_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_credit_ff   <= rsp_credit_in;
      rsp_total_ff    <= rsp_total_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_key_credit = rsp_credit_ff;
   assign rsp_total_held = rsp_total_ff;

endmodule
`default_nettype wire

FILE: design/event_credit_mailbox.sv
// a request is handled by a sweep of the entry memory, one entry a cycle through
// its single read port, then a decide step that registers the result and waits while
// the last result is still held; a new request is taken only after its decide step
// reset: synchronous, active high; clears occupancy flags, total and control,
// loads register defaults; entry memory contents are left as they are
`default_nettype none
module event_credit_mailbox (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // request channel
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic                                 req_func,
   input  wire logic [eca_pkg::CORE_W-1:0]           req_source,
   input  wire logic [eca_pkg::CORE_W-1:0]           req_destination,
   input  wire logic [eca_pkg::TAG_W-1:0]            req_tag,
   input  wire logic [eca_pkg::COUNT_W-1:0]          req_count,
   // result channel
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic [eca_pkg::STATUS_W-1:0]              rsp_status,
   output logic [eca_pkg::CREDIT_W-1:0]              rsp_key_credit,
   output logic [eca_pkg::CREDIT_W-1:0]              rsp_total_held,
   // register write port
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [eca_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire logic [eca_pkg::CSR_DATA_W-1:0]       csr_data
);

   eca_pkg::cfg_type     cfg_ff, cfg_in;
   eca_pkg::tbl_cmd_type tbl_cmd;
   eca_pkg::entry_type   tbl_rd_data;
   logic [eca_pkg::MAX_ENTRIES-1:0] tbl_valid;

   // register writes are always taken; unknown indexes fall through unchanged
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            eca_pkg::CSR_CAPACITY: begin
               cfg_in.capacity = csr_data[eca_pkg::CREDIT_W-1:0];
            end
            eca_pkg::CSR_CORE_COUNT: begin
               cfg_in.core_count = csr_data[eca_pkg::CORE_COUNT_W-1:0];
            end
            eca_pkg::CSR_OWN_CORE: begin
               cfg_in.own_core = csr_data[eca_pkg::CORE_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.capacity   <= eca_pkg::CAPACITY_RESET;
         cfg_ff.core_count <= eca_pkg::CORE_COUNT_RESET;
         cfg_ff.own_core   <= eca_pkg::OWN_CORE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // sequencer: sweeps the table for the key and the lowest free slot, then
   // writes back in its decide cycle; the next sweep starts only after that
   // write, so no forwarding path is needed
   eca_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_func        (req_func),
      .req_source      (req_source),
      .req_destination (req_destination),
      .req_tag         (req_tag),
      .req_count       (req_count),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_key_credit  (rsp_key_credit),
      .rsp_total_held  (rsp_total_held),
      .tbl_cmd         (tbl_cmd),
      .tbl_rd_data     (tbl_rd_data),
      .tbl_valid       (tbl_valid)
   );

   // entry memory with registered read and per-entry occupancy flags
   eca_table u_table (
      .clock   (clock),
      .reset   (reset),
      .cmd     (tbl_cmd),
      .rd_data (tbl_rd_data),
      .valid   (tbl_valid)
   );

endmodule
`default_nettype wire

FILE: bench/eca_tb_pkg.sv
`default_nettype none
package eca_tb_pkg;

   // request function codes as carried on req_func
   typedef enum logic {
      FUNC_DELIVER = 1'b0,
      FUNC_CONSUME = 1'b1
   } credit_func_type;

endpackage
`default_nettype wire

FILE: bench/event_credit_mailbox_checker.sv
`default_nettype none
module event_credit_mailbox_checker
   import eca_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic                  req_ready,
   input  wire logic                  req_func,
   input  wire logic [CORE_W-1:0]     req_source,
   input  wire logic [CORE_W-1:0]     req_destination,
   input  wire logic [TAG_W-1:0]      req_tag,
   input  wire logic [COUNT_W-1:0]    req_count,
   input  wire logic                  rsp_valid,
   input  wire logic                  rsp_ready,
   input  wire logic [STATUS_W-1:0]   rsp_status,
   input  wire logic [CREDIT_W-1:0]   rsp_key_credit,
   input  wire logic [CREDIT_W-1:0]   rsp_total_held,
   input  wire logic                  csr_valid,
   input  wire logic                  csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data,
   output int                         fail_count,
   output int                         reports_due,
   output int                         reports_checked,
   output logic [5:0]                 status_seen
);
   import eca_tb_pkg::*;

   localparam int DUE_DEPTH = 64;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [CREDIT_W-1:0] key_credit;
      logic [CREDIT_W-1:0] total_held;
   } credit_report_type;

   // own copy of the credit table and registers
   logic                     slot_used   [MAX_ENTRIES];
   logic [CORE_W-1:0]        slot_src    [MAX_ENTRIES];
   logic [CORE_W-1:0]        slot_dst    [MAX_ENTRIES];
   logic [TAG_W-1:0]         slot_tag    [MAX_ENTRIES];
   logic [CREDIT_W-1:0]      slot_credit [MAX_ENTRIES];
   logic [CREDIT_W-1:0]      held_total;
   logic [CREDIT_W-1:0]      cfg_capacity;
   logic [CORE_COUNT_W-1:0]  cfg_cores;
   logic [CORE_W-1:0]        cfg_own;

   // expected results in request order, kept as a ring
   credit_report_type due_buf [DUE_DEPTH];
   int                due_head;
   int                due_tail;
   int                due_level;
   int                faults;
   int                checked;

   function automatic credit_report_type apply_request(
      input logic                func,
      input logic [CORE_W-1:0]   src,
      input logic [CORE_W-1:0]   dst,
      input logic [TAG_W-1:0]    tag,
      input logic [COUNT_W-1:0]  count
   );
      credit_report_type r;
      int                hit;
      int                spare;
      hit   = -1;
      spare = -1;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         if (hit < 0 && slot_used[i] && slot_src[i] == src && slot_dst[i] == dst &&
             slot_tag[i] == tag)
            hit = i;
         if (spare < 0 && !slot_used[i])
            spare = i;
      end
      r.status = ST_OK;
      if (func == FUNC_DELIVER) begin
         if (cfg_cores == '0 || cfg_cores > CORE_LIMIT || {1'b0, src} >= cfg_cores ||
             {1'b0, dst} >= cfg_cores) begin
            r.status = ST_RANGE;
         end else if (dst != cfg_own) begin
            r.status = ST_ENDPOINT;
         end else if (held_total >= cfg_capacity) begin
            r.status = ST_FULL;
         end else begin
            if (hit < 0 && spare >= 0) begin
               slot_used[spare]   = 1'b1;
               slot_src[spare]    = src;
               slot_dst[spare]    = dst;
               slot_tag[spare]    = tag;
               slot_credit[spare] = '0;
               hit                = spare;
            end
            if (hit < 0) begin
               r.status = ST_FULL;
            end else begin
               slot_credit[hit] = slot_credit[hit] + 1'b1;
               held_total       = held_total + 1'b1;
            end
         end
      end else begin
         if (count == '0) begin
            r.status = ST_ZERO;
         end else if (hit < 0 || {11'd0, slot_credit[hit]} < count) begin
            r.status = ST_NOT_READY;
         end else begin
            slot_credit[hit] = slot_credit[hit] - count[CREDIT_W-1:0];
            held_total       = held_total - count[CREDIT_W-1:0];
            // entry released once drained
            if (slot_credit[hit] == '0) begin
               slot_used[hit] = 1'b0;
               hit            = -1;
            end
         end
      end
      r.key_credit = (hit >= 0) ? slot_credit[hit] : '0;
      r.total_held = held_total;
      return r;
   endfunction

   always @(posedge clock) begin
      credit_report_type want;
      if (reset) begin
         for (int i = 0; i < MAX_ENTRIES; i++)
            slot_used[i] = 1'b0;
         held_total   = '0;
         cfg_capacity = CAPACITY_RESET;
         cfg_cores    = CORE_COUNT_RESET;
         cfg_own      = OWN_CORE_RESET;
         due_head     = 0;
         due_tail     = 0;
         due_level    = 0;
         faults  = 0;
         checked = 0;
         status_seen <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_CAPACITY:   cfg_capacity = csr_data[CREDIT_W-1:0];
               CSR_CORE_COUNT: cfg_cores    = csr_data[CORE_COUNT_W-1:0];
               CSR_OWN_CORE:   cfg_own      = csr_data[CORE_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            checked++;
            if (rsp_status < 6)
               status_seen[rsp_status] <= 1'b1;
            if (due_level == 0) begin
               faults++;
               if (faults <= 10)
                  $display("unexpected result: status %0d key_credit %0d total %0d",
                           rsp_status, rsp_key_credit, rsp_total_held);
            end else begin
               want      = due_buf[due_head];
               due_head  = (due_head + 1) % DUE_DEPTH;
               due_level = due_level - 1;
               if (want.status != rsp_status || want.key_credit != rsp_key_credit ||
                   want.total_held != rsp_total_held) begin
                  faults++;
                  if (faults <= 10)
                     $display("mismatch at result %0d: status %0d/%0d key_credit %0d/%0d",
                              checked, want.status, rsp_status, want.key_credit,
                              rsp_key_credit, " total %0d/%0d (expected/actual)",
                              want.total_held, rsp_total_held);
               end
            end
         end
         if (req_valid && req_ready) begin
            due_buf[due_tail] = apply_request(req_func, req_source, req_destination,
                                              req_tag, req_count);
            due_tail  = (due_tail + 1) % DUE_DEPTH;
            due_level = due_level + 1;
         end
      end
      fail_count      <= faults;
      reports_due     <= due_level;
      reports_checked <= checked;
   end

endmodule
`default_nettype wire

FILE: bench/event_credit_mailbox_tb.sv
`default_nettype none
module event_credit_mailbox_tb;
   import eca_pkg::*;
   import eca_tb_pkg::*;

   // the block handles one request at a time; this covers one request's sweep and decide step
   localparam int SETTLE_CYCLES   = MAX_ENTRIES + 3;
   // long receiver hold-off so that the block backs up and stalls its input
   localparam int RSP_HOLD_CYCLES = 250;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   logic                     req_func;
   logic [CORE_W-1:0]        req_source;
   logic [CORE_W-1:0]        req_destination;
   logic [TAG_W-1:0]         req_tag;
   logic [COUNT_W-1:0]       req_count;
   logic                     rsp_valid;
   logic                     rsp_ready;
   logic [STATUS_W-1:0]      rsp_status;
   logic [CREDIT_W-1:0]      rsp_key_credit;
   logic [CREDIT_W-1:0]      rsp_total_held;
   logic                     csr_valid;
   logic                     csr_ready;
   logic [CSR_IDX_W-1:0]     csr_index;
   logic [CSR_DATA_W-1:0]    csr_data;

   int                       fail_count;
   int                       reports_due;
   int                       reports_checked;
   logic [5:0]               status_seen;

   // what the stimulus side believes the registers hold, used to aim requests
   logic [CREDIT_W-1:0]      cur_capacity;
   logic [CORE_COUNT_W-1:0]  cur_cores;
   logic [CORE_W-1:0]        cur_own;
   logic [CORE_W-1:0]        prev_own;
   int                       settings_used;
   bit                       hold_rsp;

   event_credit_mailbox u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_func        (req_func),
      .req_source      (req_source),
      .req_destination (req_destination),
      .req_tag         (req_tag),
      .req_count       (req_count),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_key_credit  (rsp_key_credit),
      .rsp_total_held  (rsp_total_held),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   // predicts every result and compares, hands back the failure count
   event_credit_mailbox_checker u_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_func        (req_func),
      .req_source      (req_source),
      .req_destination (req_destination),
      .req_tag         (req_tag),
      .req_count       (req_count),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_key_credit  (rsp_key_credit),
      .rsp_total_held  (rsp_total_held),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .fail_count      (fail_count),
      .reports_due     (reports_due),
      .reports_checked (reports_checked),
      .status_seen     (status_seen)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // idle lengths: mostly none or short, now and then a long one
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 50)
         return 0;
      else if (roll < 90)
         return $urandom_range(1, 3);
      else
         return $urandom_range(10, 40);
   endfunction

   // offer one request and hold it until the block takes it
   task automatic send(input credit_func_type f, input logic [CORE_W-1:0] src,
                       input logic [CORE_W-1:0] dst, input logic [TAG_W-1:0] tag,
                       input logic [COUNT_W-1:0] count);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      // valid stays up across back-to-back requests, only the payload moves
      req_valid       <= 1'b1;
      req_func        <= f;
      req_source      <= src;
      req_destination <= dst;
      req_tag         <= tag;
      req_count       <= count;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   // registers only change once the block has drained every outstanding request
   task automatic program_regs(input logic [CREDIT_W-1:0] cap,
                               input logic [CORE_COUNT_W-1:0] cores,
                               input logic [CORE_W-1:0] own);
      logic [CSR_DATA_W-1:0] junk;
      req_valid <= 1'b0;
      // wait for the clock first so the pending count includes a request taken just now
      @(posedge clock);
      while (reports_due != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      // unused upper data bits carry noise, only the register's own width counts
      junk = CSR_DATA_W'($urandom);
      write_csr(CSR_CAPACITY, {junk[CSR_DATA_W-1:CREDIT_W], cap});
      write_csr(CSR_CORE_COUNT, cores);
      junk = CSR_DATA_W'($urandom);
      write_csr(CSR_OWN_CORE, {junk[CSR_DATA_W-1:CORE_W], own});
      csr_valid    <= 1'b0;
      prev_own      = cur_own;
      cur_capacity  = cap;
      cur_cores     = cores;
      cur_own       = own;
      settings_used++;
   endtask

   // mostly well-aimed requests on a small key set so that credits pile up,
   // entries get reused and the full and drain paths are reached; the rest is noise
   task automatic random_request(input int tag_span, input int deliver_pct);
      credit_func_type    f;
      logic [CORE_W-1:0]  src;
      logic [CORE_W-1:0]  dst;
      logic [TAG_W-1:0]   tag;
      logic [COUNT_W-1:0] count;
      int                 roll;
      roll = $urandom_range(0, 99);
      if (roll < 12) begin
         if ($urandom_range(0, 1) == 1)
            f = FUNC_CONSUME;
         else
            f = FUNC_DELIVER;
         src   = CORE_W'($urandom);
         dst   = CORE_W'($urandom);
         tag   = TAG_W'($urandom);
         count = COUNT_W'($urandom);
      end else begin
         if ($urandom_range(0, 99) < deliver_pct)
            f = FUNC_DELIVER;
         else
            f = FUNC_CONSUME;
         src = CORE_W'($urandom_range(0, 3));
         tag = TAG_W'($urandom_range(0, tag_span));
         if (f == FUNC_DELIVER) begin
            // occasionally aimed at the previous endpoint to hit the wrong endpoint path
            dst   = ($urandom_range(0, 9) == 0) ? prev_own : cur_own;
            count = COUNT_W'($urandom);
         end else begin
            // consumes also drain keys left behind under the previous endpoint
            dst  = ($urandom_range(0, 1) == 0) ? prev_own : cur_own;
            roll = $urandom_range(0, 19);
            if (roll == 0)
               count = '0;
            else if (roll == 1)
               count = COUNT_W'($urandom);
            else
               count = COUNT_W'($urandom_range(1, 3));
         end
      end
      send(f, src, dst, tag, count);
   endtask

   task automatic run_phase(input logic [CREDIT_W-1:0] cap,
                            input logic [CORE_COUNT_W-1:0] cores,
                            input logic [CORE_W-1:0] own, input int tag_span,
                            input int deliver_pct, input int n, input bit squeeze);
      program_regs(cap, cores, own);
      if (squeeze)
         hold_rsp = 1'b1;
      repeat (n) random_request(tag_span, deliver_pct);
   endtask

   // result side: random back-pressure, plus one long hold-off on request
   initial begin
      int gap;
      rsp_ready = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end else begin
            gap = pick_gap();
            if (gap > 0) begin
               rsp_ready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
            rsp_ready <= 1'b1;
            if ($urandom_range(0, 9) == 0)
               repeat ($urandom_range(30, 60)) @(posedge clock);
            else
               repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end
   end

   // stimulus and verdict
   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_func        = FUNC_DELIVER;
      req_source      = '0;
      req_destination = '0;
      req_tag         = '0;
      req_count       = '0;
      csr_valid       = 1'b0;
      csr_index       = CSR_CAPACITY;
      csr_data        = '0;
      hold_rsp        = 1'b0;
      settings_used   = 1;
      cur_capacity    = CAPACITY_RESET;
      cur_cores       = CORE_COUNT_RESET;
      cur_own         = OWN_CORE_RESET;
      prev_own        = OWN_CORE_RESET;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // reset defaults: absent key, zero count, top-end key, wrong endpoint
      send(FUNC_CONSUME, 16'd5,      16'd0,      16'd7,      16'd1);
      send(FUNC_CONSUME, 16'd5,      16'd0,      16'd7,      16'd0);
      send(FUNC_DELIVER, 16'hffff,   16'd0,      16'hffff,   16'd0);
      send(FUNC_DELIVER, 16'hffff,   16'd0,      16'hffff,   16'hffff);
      send(FUNC_DELIVER, 16'hffff,   16'd1,      16'hffff,   16'd0);
      send(FUNC_CONSUME, 16'hffff,   16'd0,      16'hffff,   16'hffff);
      // drains the key to zero, entry is released
      send(FUNC_CONSUME, 16'hffff,   16'd0,      16'hffff,   16'd2);
      send(FUNC_DELIVER, 16'd0,      16'd0,      16'd0,      16'hffff);
      send(FUNC_DELIVER, 16'd0,      16'hffff,   16'd0,      16'd0);

      // capacity at the held total blocks delivers; cores just in and out of range;
      // consume ignores range and endpoint
      program_regs(5'd1, 17'd2, 16'd1);
      send(FUNC_DELIVER, 16'd1,      16'd1,      16'd5,      16'd0);
      send(FUNC_DELIVER, 16'd2,      16'd1,      16'd0,      16'd0);
      send(FUNC_DELIVER, 16'd0,      16'd2,      16'd0,      16'd0);
      send(FUNC_CONSUME, 16'd0,      16'd0,      16'd0,      16'd1);
      send(FUNC_DELIVER, 16'd1,      16'd1,      16'd5,      16'd0);
      send(FUNC_DELIVER, 16'd0,      16'd1,      16'd5,      16'd0);
      send(FUNC_CONSUME, 16'd1,      16'd1,      16'd5,      16'd1);

      // bad core counts: zero and above the core limit
      program_regs(5'd16, 17'd0, 16'd0);
      send(FUNC_DELIVER, 16'd0,      16'd0,      16'd0,      16'd0);
      program_regs(5'd16, 17'h1ffff, 16'd0);
      send(FUNC_DELIVER, 16'd0,      16'd0,      16'd0,      16'd0);

      // capacity zero is always full, highest endpoint id
      program_regs(5'd0, CORE_LIMIT, 16'hffff);
      send(FUNC_DELIVER, 16'hffff,   16'hffff,   16'hffff,   16'd0);
      send(FUNC_CONSUME, 16'hffff,   16'hffff,   16'hffff,   16'd0);
      send(FUNC_CONSUME, 16'hffff,   16'hffff,   16'hffff,   16'd1);

      // random phases; the capacity-31 phase is deliver-heavy over many keys so the
      // table runs out of entries, the next one starts with the total above capacity
      run_phase(5'd16, CORE_LIMIT, 16'd0, 5, 55, 110, 1'b0);
      run_phase(5'd31, CORE_LIMIT, 16'hffff, 23, 80, 110, 1'b0);
      run_phase(5'd3, 17'd4, 16'd3, 23, 30, 110, 1'b0);
      begin
         logic [CORE_COUNT_W-1:0] cores;
         cores = CORE_COUNT_W'($urandom_range(1, 65536));
         run_phase(CREDIT_W'($urandom_range(1, 16)), cores,
                   CORE_W'($urandom_range(0, cores - 1)), 7, 55, 110, 1'b0);
      end
      // receiver hold-off in this phase backs the block up
      run_phase(5'd16, CORE_LIMIT, CORE_W'($urandom), 4, 50, 110, 1'b1);

      req_valid <= 1'b0;
      @(posedge clock);
      while (reports_due != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("run covered %0d results under %0d register settings", reports_checked,
               settings_used);
      $display("status codes returned (bit per code): %b", status_seen);
      if (fail_count == 0 && reports_due == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // watchdog well beyond the slowest legal run
   initial begin
      #4000000;
      $display("timeout waiting on the block");
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
`default_nettype wire
